/* src/gde_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gde_pkg
// Shared types, codes and result builders for the grid DFS explorer.
// ----------------------------------------------------------------------------
package gde_pkg;

  localparam int MAP_IDX_W = 16;

  localparam logic OP_ANSWER = 1'b1;

  localparam logic [2:0] KIND_MARKED  = 3'd2;
  localparam logic [2:0] KIND_CONTACT = 3'd3;
  localparam logic [2:0] KIND_OTHER   = 3'd4;
  localparam logic [2:0] KIND_UNKNOWN = 3'd7;

  localparam logic [1:0] RK_STATUS  = 2'd0;
  localparam logic [1:0] RK_MOVE    = 2'd1;
  localparam logic [1:0] RK_REQUEST = 2'd2;

  localparam logic [2:0] STAT_EXPLORING = 3'd0;
  localparam logic [2:0] STAT_ENGAGING  = 3'd1;
  localparam logic [2:0] STAT_RETURNING = 3'd2;
  localparam logic [2:0] STAT_DONE      = 3'd3;
  localparam logic [2:0] STAT_FAILED    = 3'd4;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef struct packed {
    logic        operation;
    logic [5:0]  robot_x;
    logic [5:0]  robot_y;
    logic        cell_present;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic [2:0]  cell_kind;
    logic [15:0] contact_tag;
    logic        last_cell;
    logic        payload_ready;
    logic        payload_accepted;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  status_code;
    logic [1:0]  direction;
    logic [15:0] request_tag;
    logic [5:0]  request_x;
    logic [5:0]  request_y;
    logic        last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_NB_RD, S_NB_CHK, S_POP_CHK, S_SEND
  } fsm_t;

  typedef struct packed {
    logic [MAP_IDX_W-1:0] rd_idx;
    logic                 kind_we;
    logic [MAP_IDX_W-1:0] kind_idx;
    logic [2:0]           kind;
    logic                 vis_we;
    logic [MAP_IDX_W-1:0] vis_idx;
  } map_req_t;

  typedef struct packed {
    logic       busy;
    logic [2:0] kind;
    logic       visited;
  } map_rsp_t;

  function automatic out_item_t status_res(input logic [2:0] code);
    out_item_t r;
    r = '0;
    r.result_kind = RK_STATUS;
    r.status_code = code;
    return r;
  endfunction

  function automatic out_item_t move_res(input logic [1:0] dir);
    out_item_t r;
    r = '0;
    r.result_kind = RK_MOVE;
    r.direction = dir;
    return r;
  endfunction

  function automatic out_item_t req_res(input logic [15:0] tag, input logic [5:0] x,
                                        input logic [5:0] y);
    out_item_t r;
    r = '0;
    r.result_kind = RK_REQUEST;
    r.request_tag = tag;
    r.request_x = x;
    r.request_y = y;
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/gde_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gde_if
// Valid/ready channels for scan beats and result beats.
// ----------------------------------------------------------------------------
interface gde_in_if import gde_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface gde_out_if import gde_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/gde_map.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gde_map
// Cell kind and visited memories with a clearing pass after reset.
// ----------------------------------------------------------------------------
module gde_map import gde_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int IW = 12
) (
  input  logic     clk,
  input  logic     rst,
  input  map_req_t req,
  output map_rsp_t rsp
);

  logic [2:0]    kind_mem [DEPTH];
  logic          vis_mem  [DEPTH];
  logic [IW-1:0] clr_idx;
  logic          busy;
  logic          kind_we, vis_we;
  logic [IW-1:0] kind_wa, vis_wa;
  logic [2:0]    kind_wd;
  logic          vis_wd;
  logic [2:0]    kind_q;
  logic          vis_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + IW'(1);
      if (clr_idx == IW'(DEPTH - 1)) busy <= 1'b0;
    end
  end

  always_comb begin
    if (busy) begin
      kind_we = 1'b1;
      kind_wa = clr_idx;
      kind_wd = KIND_UNKNOWN;
      vis_we  = 1'b1;
      vis_wa  = clr_idx;
      vis_wd  = 1'b0;
    end else begin
      kind_we = req.kind_we;
      kind_wa = req.kind_idx[IW-1:0];
      kind_wd = req.kind;
      vis_we  = req.vis_we;
      vis_wa  = req.vis_idx[IW-1:0];
      vis_wd  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (kind_we) kind_mem[kind_wa] <= kind_wd;
    kind_q <= kind_mem[req.rd_idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_q <= vis_mem[req.rd_idx[IW-1:0]];
  end

  assign rsp.busy    = busy;
  assign rsp.kind    = kind_q;
  assign rsp.visited = vis_q;

endmodule
`default_nettype wire

/* src/grid_dfs_explorer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// grid_dfs_explorer_unit
// Online depth-first explorer of a grid world, fed by robot scans.
// ----------------------------------------------------------------------------
// Channels: scan (sink) takes one beat per observed cell or payload answer;
// result (source) gives status, move and payload request beats, the final
// beat of each input flagged by last_result.
// Sequence: a scan beat or payload answer is taken in S_IDLE, handled in
// S_EXEC. A final scan beat with no contact held probes up to 4 neighbors
// (S_NB_RD, S_NB_CHK) via the map's single read port, may pop a backtrack
// entry (S_POP_CHK), then sends one result beat per cycle unless stalled.
// Reset: a clearing pass writes all GRID_SIDE*GRID_SIDE map entries;
// scan.ready stays low until it ends.
// Stall: one item at a time; while the receiver holds result.ready low, the
// pending beat holds and no new scan beat is taken.
// ----------------------------------------------------------------------------
module grid_dfs_explorer_unit import gde_pkg::*; #(
  parameter int GRID_SIDE = 64
) (
  input logic       clk,
  input logic       rst,
  gde_in_if.sink    scan,
  gde_out_if.source result
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int IW = $clog2(CELLS);
  localparam int SW = IW + 1;

  fsm_t          state, state_next;
  in_item_t      item;
  logic [5:0]    here_x, here_y, home_x, home_y, tgt_x, tgt_y;
  logic          have_home, engaging, waiting, done_q, held_valid;
  logic [15:0]   held_tag;
  logic [5:0]    held_x, held_y;
  logic [SW-1:0] stack_count;
  logic [1:0]    nb;
  out_item_t     res [3];
  logic [1:0]    res_n, send_i;
  logic [11:0]   stack_mem [CELLS];
  logic [11:0]   stack_q;
  map_req_t      map_req;
  map_rsp_t      map_rsp;

  function automatic logic [IW-1:0] cell_idx(input logic [8:0] x, input logic [8:0] y);
    return IW'(y) * IW'(GRID_SIDE) + IW'(x);
  endfunction

  gde_map #(.DEPTH(CELLS), .IW(IW)) u_map (
    .clk(clk), .rst(rst), .req(map_req), .rsp(map_rsp)
  );

  // item decode
  logic [2:0]  kind_c;
  logic        r_on, c_on, is_scan, pass, grab, held_any, last;
  logic [15:0] tag_sel;
  logic [5:0]  hx_sel, hy_sel;
  assign kind_c   = (item.cell_kind > KIND_OTHER) ? KIND_OTHER : item.cell_kind;
  assign r_on     = ({3'b0, item.robot_x} < 9'(GRID_SIDE)) &&
                    ({3'b0, item.robot_y} < 9'(GRID_SIDE));
  assign c_on     = ({3'b0, item.cell_x} < 9'(GRID_SIDE)) &&
                    ({3'b0, item.cell_y} < 9'(GRID_SIDE));
  assign is_scan  = item.operation != OP_ANSWER;
  assign last     = item.last_cell;
  assign pass     = is_scan && !done_q &&
                    !(waiting && (item.robot_x != tgt_x || item.robot_y != tgt_y));
  assign grab     = item.cell_present && kind_c == KIND_CONTACT && !held_valid;
  assign held_any = held_valid || grab;
  assign tag_sel  = held_valid ? held_tag : item.contact_tag;
  assign hx_sel   = held_valid ? held_x : item.cell_x;
  assign hy_sel   = held_valid ? held_y : item.cell_y;

  // neighbor probe: up, right, down, left
  logic [8:0] nx, ny;
  logic [1:0] n_dir;
  logic       n_on, nb_ok, push_ok;
  always_comb begin
    nx = {3'b0, here_x};
    ny = {3'b0, here_y};
    n_dir = DIR_UP;
    case (nb)
      2'd0: begin ny = {3'b0, here_y} - 9'd1; n_dir = DIR_UP; end
      2'd1: begin nx = {3'b0, here_x} + 9'd1; n_dir = DIR_RIGHT; end
      2'd2: begin ny = {3'b0, here_y} + 9'd1; n_dir = DIR_DOWN; end
      default: begin nx = {3'b0, here_x} - 9'd1; n_dir = DIR_LEFT; end
    endcase
  end
  assign n_on    = (nx < 9'(GRID_SIDE)) && (ny < 9'(GRID_SIDE));
  assign nb_ok   = n_on && map_rsp.kind <= KIND_MARKED && !map_rsp.visited;
  assign push_ok = stack_count < SW'(CELLS);

  // backtrack target check
  logic [5:0] ex, ey;
  logic       adj;
  logic [1:0] p_dir;
  assign ex = stack_q[5:0];
  assign ey = stack_q[11:6];
  always_comb begin
    adj = 1'b1;
    p_dir = DIR_UP;
    if (ex == here_x && {1'b0, ey} + 7'd1 == {1'b0, here_y}) p_dir = DIR_UP;
    else if (ex == here_x && {1'b0, ey} == {1'b0, here_y} + 7'd1) p_dir = DIR_DOWN;
    else if (ey == here_y && {1'b0, ex} + 7'd1 == {1'b0, here_x}) p_dir = DIR_LEFT;
    else if (ey == here_y && {1'b0, ex} == {1'b0, here_x} + 7'd1) p_dir = DIR_RIGHT;
    else adj = 1'b0;
  end

  // return stack memory
  logic [SW-1:0] cnt_dec;
  logic          stk_we;
  assign cnt_dec = stack_count - SW'(1);
  assign stk_we  = (state == S_NB_CHK) && nb_ok && push_ok;
  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stack_count[IW-1:0]] <= {here_y, here_x};
    stack_q <= stack_mem[cnt_dec[IW-1:0]];
  end

  // map accesses
  always_comb begin
    map_req = '0;
    if (state == S_EXEC && pass) begin
      map_req.vis_we   = r_on;
      map_req.vis_idx  = MAP_IDX_W'(cell_idx({3'b0, item.robot_x}, {3'b0, item.robot_y}));
      map_req.kind_we  = item.cell_present && c_on;
      map_req.kind_idx = MAP_IDX_W'(cell_idx({3'b0, item.cell_x}, {3'b0, item.cell_y}));
      map_req.kind     = kind_c;
    end
    if (state == S_NB_RD) map_req.rd_idx = MAP_IDX_W'(cell_idx(nx, ny));
  end

  logic send_last;
  assign send_last = send_i == res_n - 2'd1;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (!map_rsp.busy) state_next = S_IDLE;
      S_IDLE: if (scan.valid) state_next = S_EXEC;
      S_EXEC: begin
        if (!is_scan) state_next = (engaging && !item.payload_accepted) ? S_SEND : S_IDLE;
        else if (pass && last && !engaging) state_next = held_any ? S_SEND : S_NB_RD;
        else state_next = S_IDLE;
      end
      S_NB_RD: state_next = S_NB_CHK;
      S_NB_CHK: begin
        if (nb_ok) state_next = S_SEND;
        else if (nb == 2'd3) state_next = (stack_count != '0) ? S_POP_CHK : S_SEND;
        else state_next = S_NB_RD;
      end
      S_POP_CHK: state_next = S_SEND;
      S_SEND: if (result.ready && send_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_home   <= 1'b0;
      engaging    <= 1'b0;
      waiting     <= 1'b0;
      done_q      <= 1'b0;
      held_valid  <= 1'b0;
      stack_count <= '0;
      here_x <= '0; here_y <= '0;
      home_x <= '0; home_y <= '0;
      tgt_x  <= '0; tgt_y  <= '0;
      res_n  <= '0;
      send_i <= '0;
      nb     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (scan.valid) item <= scan.data;
          res_n <= '0;
        end
        S_EXEC: begin
          if (!is_scan) begin
            if (engaging) begin
              engaging <= 1'b0;
              res[0] <= status_res(STAT_FAILED);
              res_n <= 2'd1;
            end
          end else begin
            if (!done_q && !have_home) begin
              home_x <= item.robot_x;
              home_y <= item.robot_y;
              have_home <= 1'b1;
            end
            if (pass) begin
              waiting <= 1'b0;
              here_x <= item.robot_x;
              here_y <= item.robot_y;
              if (last && !engaging) begin
                if (held_any) begin
                  res[0] <= status_res(STAT_ENGAGING);
                  if (item.payload_ready) begin
                    engaging <= 1'b1;
                    res[1] <= req_res(tag_sel, hx_sel, hy_sel);
                  end else begin
                    res[1] <= status_res(STAT_FAILED);
                  end
                  res_n <= 2'd2;
                end else begin
                  res[0] <= status_res(STAT_EXPLORING);
                  res_n <= 2'd1;
                  nb <= '0;
                end
              end
            end
            // the held contact lives for one scan only
            if (last) begin
              held_valid <= 1'b0;
            end else if (pass && grab) begin
              held_valid <= 1'b1;
              held_tag <= item.contact_tag;
              held_x <= item.cell_x;
              held_y <= item.cell_y;
            end
          end
        end
        S_NB_CHK: begin
          if (nb_ok) begin
            if (push_ok) stack_count <= stack_count + SW'(1);
            tgt_x <= nx[5:0];
            tgt_y <= ny[5:0];
            waiting <= 1'b1;
            res[1] <= move_res(n_dir);
            res_n <= 2'd2;
          end else if (nb == 2'd3) begin
            if (stack_count != '0) begin
              stack_count <= cnt_dec;
            end else begin
              res[1] <= status_res(STAT_RETURNING);
              if (here_x == home_x && here_y == home_y) begin
                done_q <= 1'b1;
                res[2] <= status_res(STAT_DONE);
              end else begin
                res[2] <= status_res(STAT_FAILED);
              end
              res_n <= 2'd3;
            end
          end else begin
            nb <= nb + 2'd1;
          end
        end
        S_POP_CHK: begin
          if (adj) begin
            tgt_x <= ex;
            tgt_y <= ey;
            waiting <= 1'b1;
            res[1] <= move_res(p_dir);
          end else begin
            res[1] <= status_res(STAT_FAILED);
          end
          res_n <= 2'd2;
        end
        S_SEND: begin
          if (result.ready) send_i <= send_last ? 2'd0 : send_i + 2'd1;
        end
        default: ;
      endcase
    end
  end

  assign scan.ready = state == S_IDLE;
  assign result.valid = state == S_SEND;
  always_comb begin
    result.data = res[send_i];
    result.data.last_result = send_last;
  end

endmodule
`default_nettype wire
